// File: rtl/core/sqwt_pkg.sv
// Shared constants, register indexes and item control type of the quality window trimmer.
package sqwt_pkg;

  localparam int SCORE_W     = 8;
  localparam int KEPT_W      = 17;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 8;
  localparam int WSIZE_W     = 7;
  localparam int STEP_W      = 7;
  localparam int MAX_STEP    = 64;
  localparam int PHASE_W     = 6;
  localparam int THR_W       = 8;
  localparam int STREAK_W    = 8;
  localparam int STREAK_MAX  = 255;
  localparam int FIFO_DEPTH  = 4;

  localparam int WSIZE_RESET  = 10;
  localparam int STEP_RESET   = 1;
  localparam int THR_RESET    = 20;
  localparam int STREAK_RESET = 3;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_WINDOW_SIZE       = 2'd0,
    REG_WINDOW_STEP       = 2'd1,
    REG_QUALITY_THRESHOLD = 2'd2,
    REG_STREAK_NEEDED     = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic counted;
    logic sub;
    logic eval;
    logic last;
  } item_ctrl_t;

endpackage

// File: rtl/core/sqwt_fifo.sv
// Short queue of classified items between the front and back parts.
module sqwt_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int Depth = sqwt_pkg::FIFO_DEPTH;
  localparam int PtrW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);

  logic [WIDTH-1:0] slots [Depth];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [CntW-1:0]  count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == CntW'(Depth));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CntW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

// File: rtl/core/sqwt_front.sv
// Front part: accepts scores, keeps the score ring and classifies each item for the back part.
module sqwt_front #(
  parameter int MAX_WINDOW   = 64,
  parameter int MAX_READ_LEN = 65536,
  localparam int WinW = $clog2(MAX_WINDOW + 1),
  localparam int PosW = $clog2(MAX_READ_LEN + 1)
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [sqwt_pkg::SCORE_W-1:0]     in_score,
  input  logic                             in_last,
  input  logic [WinW-1:0]                  win,
  input  logic [sqwt_pkg::STEP_W-1:0]      step,
  output logic                             out_valid,
  input  logic                             out_ready,
  output sqwt_pkg::item_ctrl_t             out_ctrl,
  output logic [sqwt_pkg::SCORE_W-1:0]     out_score,
  output logic [sqwt_pkg::SCORE_W-1:0]     out_old,
  output logic [PosW-1:0]                  out_start,
  output logic [PosW-1:0]                  out_len
);

  localparam int AddrW   = $clog2(MAX_WINDOW);
  localparam int PtrW    = WinW + 1;
  localparam int PosIncW = PosW + 1;
  localparam int StepW   = sqwt_pkg::STEP_W;
  localparam int PhaseW  = sqwt_pkg::PHASE_W;

  logic [sqwt_pkg::SCORE_W-1:0] ring [MAX_WINDOW];
  logic [PosW-1:0]              pos;
  logic [AddrW-1:0]             wr_ptr;
  logic [PhaseW-1:0]            phase;
  logic                         fv;

  logic                         accept;
  logic [PosIncW-1:0]           pos_inc;
  logic                         counted;
  logic                         complete;
  logic                         sub;
  logic                         eval;
  logic [PtrW-1:0]              ptr_ext;
  logic [AddrW-1:0]             rd_ptr;
  logic [StepW-1:0]             phase_inc;
  logic [PhaseW-1:0]            phase_next;

  assign in_ready  = !fv || out_ready;
  assign accept    = in_valid && in_ready;
  assign out_valid = fv;

  assign pos_inc    = {1'b0, pos} + PosIncW'(1);
  assign counted    = (pos < PosW'(MAX_READ_LEN));
  assign complete   = counted && (pos_inc >= PosIncW'(win));
  assign sub        = counted && ({1'b0, pos} >= PosIncW'(win));
  assign eval       = complete && (phase == '0);
  assign ptr_ext    = PtrW'(wr_ptr);
  assign phase_inc  = StepW'(phase) + StepW'(1);
  assign phase_next = (phase_inc >= step) ? '0 : phase_inc[PhaseW-1:0];

  always_comb begin
    if (ptr_ext >= PtrW'(win)) begin
      rd_ptr = AddrW'(ptr_ext - PtrW'(win));
    end else begin
      rd_ptr = AddrW'(ptr_ext + PtrW'(MAX_WINDOW) - PtrW'(win));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fv     <= 1'b0;
      pos    <= '0;
      wr_ptr <= '0;
      phase  <= '0;
    end else begin
      if (accept) begin
        fv <= 1'b1;
        if (in_last) begin
          pos    <= '0;
          wr_ptr <= '0;
          phase  <= '0;
        end else if (counted) begin
          pos    <= pos_inc[PosW-1:0];
          wr_ptr <= (wr_ptr == AddrW'(MAX_WINDOW - 1)) ? '0 : wr_ptr + AddrW'(1);
          if (complete) begin
            phase <= phase_next;
          end
        end
      end else if (out_ready) begin
        fv <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_ctrl  <= '{counted: counted, sub: sub, eval: eval, last: in_last};
      out_score <= in_score;
      out_start <= PosW'(pos_inc - PosIncW'(win));
      out_len   <= counted ? pos_inc[PosW-1:0] : pos;
    end
  end

  // The read of the leaving score sees the ring before this item's write.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_old <= ring[rd_ptr];
      if (counted) begin
        ring[wr_ptr] <= in_score;
      end
    end
  end

endmodule

// File: rtl/core/sqwt_back.sv
// Back part: running window sum, low streak, cut decision and the result register.
module sqwt_back #(
  parameter int MAX_WINDOW   = 64,
  parameter int MAX_READ_LEN = 65536,
  localparam int WinW = $clog2(MAX_WINDOW + 1),
  localparam int PosW = $clog2(MAX_READ_LEN + 1)
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_take,
  input  sqwt_pkg::item_ctrl_t            in_ctrl,
  input  logic [sqwt_pkg::SCORE_W-1:0]    in_score,
  input  logic [sqwt_pkg::SCORE_W-1:0]    in_old,
  input  logic [PosW-1:0]                 in_start,
  input  logic [PosW-1:0]                 in_len,
  input  logic [WinW-1:0]                 win,
  input  logic [sqwt_pkg::THR_W-1:0]      thr,
  input  logic [sqwt_pkg::STREAK_W-1:0]   need,
  output logic                            out_valid,
  input  logic                            out_pop,
  output logic [sqwt_pkg::KEPT_W-1:0]     kept_length,
  output logic                            was_trimmed
);

  localparam int SumW    = $clog2(MAX_WINDOW * 255 + 1);
  localparam int SumIncW = SumW + 1;
  localparam int ProdW   = sqwt_pkg::THR_W + WinW;
  localparam int KeptW   = sqwt_pkg::KEPT_W;
  localparam int StrW    = sqwt_pkg::STREAK_W;

  logic [SumW-1:0]    sum;
  logic [StrW-1:0]    streak;
  logic               cut;
  logic [PosW-1:0]    cut_pos;

  logic [SumIncW-1:0] sum_add;
  logic [SumW-1:0]    sum_next;
  logic [ProdW-1:0]   limit;
  logic               low;
  logic               active;
  logic [StrW-1:0]    streak_next;
  logic               hit;
  logic               cut_next;
  logic [PosW-1:0]    cut_pos_next;

  assign in_take  = in_valid && (!in_ctrl.last || !out_valid || out_pop);
  assign sum_add  = SumIncW'(sum) + (in_ctrl.counted ? SumIncW'(in_score) : '0);
  assign sum_next = SumW'(sum_add - (in_ctrl.sub ? SumIncW'(in_old) : '0));
  assign limit    = ProdW'(thr) * ProdW'(win);
  assign low      = (ProdW'(sum_next) <= limit);
  assign active   = in_ctrl.eval && !cut;

  always_comb begin
    streak_next = streak;
    if (active) begin
      if (low) begin
        streak_next = (streak == StrW'(sqwt_pkg::STREAK_MAX)) ? streak : streak + StrW'(1);
      end else begin
        streak_next = '0;
      end
    end
  end

  assign hit          = active && (streak_next == need);
  assign cut_next     = cut || hit;
  assign cut_pos_next = hit ? in_start : cut_pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sum       <= '0;
      streak    <= '0;
      cut       <= 1'b0;
    end else begin
      if (in_take && in_ctrl.last) begin
        out_valid <= 1'b1;
      end else if (out_pop) begin
        out_valid <= 1'b0;
      end
      if (in_take) begin
        if (in_ctrl.last) begin
          sum    <= '0;
          streak <= '0;
          cut    <= 1'b0;
        end else begin
          sum    <= sum_next;
          streak <= streak_next;
          cut    <= cut_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      cut_pos <= cut_pos_next;
      if (in_ctrl.last) begin
        kept_length <= KeptW'(cut_next ? cut_pos_next : in_len);
        was_trimmed <= cut_next;
      end
    end
  end

endmodule

// File: rtl/core/sliding_quality_window_trimmer.sv
// Top level of the sliding window quality trimmer: configuration registers, front, queue and back.
// One quality score is taken per clock cycle for as long as results are popped; a score passes
// through the front register and the queue to the back part, which registers the result of a read
// when it takes the read's last score. The rate is set by the running window sum in the back part,
// which takes one score a cycle, and by the score ring in the front part, which gives one write
// and one read port a cycle. A four-entry queue between the two parts absorbs a stalled result;
// the front stops taking scores only when that queue and the front register are both occupied.
module sliding_quality_window_trimmer #(
  parameter int MAX_WINDOW   = 64,
  parameter int MAX_READ_LEN = 65536
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic [sqwt_pkg::SCORE_W-1:0]      quality_score,
  input  logic                              end_of_read,
  output logic                              empty,
  input  logic                              pop,
  output logic [sqwt_pkg::KEPT_W-1:0]       kept_length,
  output logic                              was_trimmed,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sqwt_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [sqwt_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int WinW   = $clog2(MAX_WINDOW + 1);
  localparam int PosW   = $clog2(MAX_READ_LEN + 1);
  localparam int ScoreW = sqwt_pkg::SCORE_W;
  localparam int CtrlW  = $bits(sqwt_pkg::item_ctrl_t);
  localparam int QW     = CtrlW + 2 * ScoreW + 2 * PosW;
  localparam int WsW    = sqwt_pkg::WSIZE_W;
  localparam int StepW  = sqwt_pkg::STEP_W;

  logic [WsW-1:0]                    window_size;
  logic [StepW-1:0]                  window_step;
  logic [sqwt_pkg::THR_W-1:0]        quality_threshold;
  logic [sqwt_pkg::STREAK_W-1:0]     streak_needed;
  logic [WinW-1:0]                   win;
  logic [StepW-1:0]                  step;

  logic                              in_ready;
  logic                              f_valid;
  logic                              q_full;
  logic                              q_empty;
  logic                              b_take;
  logic                              out_valid;
  sqwt_pkg::item_ctrl_t              f_ctrl;
  sqwt_pkg::item_ctrl_t              b_ctrl;
  logic [ScoreW-1:0]                 f_score;
  logic [ScoreW-1:0]                 f_old;
  logic [ScoreW-1:0]                 b_score;
  logic [ScoreW-1:0]                 b_old;
  logic [PosW-1:0]                   f_start;
  logic [PosW-1:0]                   f_len;
  logic [PosW-1:0]                   b_start;
  logic [PosW-1:0]                   b_len;
  logic [QW-1:0]                     q_in;
  logic [QW-1:0]                     q_out;

  assign cfg_ready = 1'b1;
  assign full      = !in_ready;
  assign empty     = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size       <= WsW'(sqwt_pkg::WSIZE_RESET);
      window_step       <= StepW'(sqwt_pkg::STEP_RESET);
      quality_threshold <= sqwt_pkg::THR_W'(sqwt_pkg::THR_RESET);
      streak_needed     <= sqwt_pkg::STREAK_W'(sqwt_pkg::STREAK_RESET);
    end else if (cfg_valid && cfg_ready) begin
      case (sqwt_pkg::reg_index_t'(cfg_index))
        sqwt_pkg::REG_WINDOW_SIZE:       window_size       <= cfg_data[WsW-1:0];
        sqwt_pkg::REG_WINDOW_STEP:       window_step       <= cfg_data[StepW-1:0];
        sqwt_pkg::REG_QUALITY_THRESHOLD: quality_threshold <= cfg_data;
        sqwt_pkg::REG_STREAK_NEEDED:     streak_needed     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Out-of-range window sizes and steps are clamped to the nearest legal value.
  always_comb begin
    if (window_size == '0) begin
      win = WinW'(1);
    end else if (32'(window_size) > MAX_WINDOW) begin
      win = WinW'(MAX_WINDOW);
    end else begin
      win = WinW'(window_size);
    end
    if (window_step == '0) begin
      step = StepW'(1);
    end else if (window_step > StepW'(sqwt_pkg::MAX_STEP)) begin
      step = StepW'(sqwt_pkg::MAX_STEP);
    end else begin
      step = window_step;
    end
  end

  sqwt_front #(
    .MAX_WINDOW   (MAX_WINDOW),
    .MAX_READ_LEN (MAX_READ_LEN)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (push),
    .in_ready  (in_ready),
    .in_score  (quality_score),
    .in_last   (end_of_read),
    .win       (win),
    .step      (step),
    .out_valid (f_valid),
    .out_ready (!q_full),
    .out_ctrl  (f_ctrl),
    .out_score (f_score),
    .out_old   (f_old),
    .out_start (f_start),
    .out_len   (f_len)
  );

  assign q_in = {f_ctrl, f_score, f_old, f_start, f_len};
  assign {b_ctrl, b_score, b_old, b_start, b_len} = q_out;

  sqwt_fifo #(
    .WIDTH (QW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (f_valid),
    .push_data (q_in),
    .full      (q_full),
    .pop       (b_take),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  sqwt_back #(
    .MAX_WINDOW   (MAX_WINDOW),
    .MAX_READ_LEN (MAX_READ_LEN)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (!q_empty),
    .in_take     (b_take),
    .in_ctrl     (b_ctrl),
    .in_score    (b_score),
    .in_old      (b_old),
    .in_start    (b_start),
    .in_len      (b_len),
    .win         (win),
    .thr         (quality_threshold),
    .need        (streak_needed),
    .out_valid   (out_valid),
    .out_pop     (pop && out_valid),
    .kept_length (kept_length),
    .was_trimmed (was_trimmed)
  );

endmodule

// File: rtl/core/sqwt_checker.sv
// Port-level checks of the quality window trimmer and their binding to the top level.
module sqwt_checker #(
  parameter int MAX_READ_LEN = 65536
) (
  input logic                              clk,
  input logic                              rst,
  input logic                              push,
  input logic                              full,
  input logic                              empty,
  input logic                              pop,
  input logic [sqwt_pkg::KEPT_W-1:0]       kept_length,
  input logic                              was_trimmed,
  input logic                              cfg_ready
);

  localparam int KeptLimit = 1 << sqwt_pkg::KEPT_W;
  localparam bit LenFits   = (MAX_READ_LEN < KeptLimit);

  // After reset nothing waits and the input side is open.
  a_reset_clears: assert property (@(posedge clk)
    rst |=> empty && !full)
    else $error("block not cleared after reset");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(kept_length) && $stable(was_trimmed))
    else $error("waiting result changed before it was taken");

  // Every read has at least one score, so an untrimmed read keeps at least one base.
  a_untrimmed_nonzero: assert property (@(posedge clk) disable iff (rst)
    LenFits && !empty && !was_trimmed |-> kept_length != '0)
    else $error("untrimmed read reported with zero length");

  a_length_bounded: assert property (@(posedge clk) disable iff (rst)
    LenFits && !empty |-> 32'(kept_length) <= MAX_READ_LEN)
    else $error("kept length beyond the longest read");

  a_cfg_open: assert property (@(posedge clk) disable iff (rst)
    cfg_ready)
    else $error("configuration port refused a write");

endmodule

bind sliding_quality_window_trimmer sqwt_checker #(
  .MAX_READ_LEN (MAX_READ_LEN)
) u_checker (
  .clk         (clk),
  .rst         (rst),
  .push        (push),
  .full        (full),
  .empty       (empty),
  .pop         (pop),
  .kept_length (kept_length),
  .was_trimmed (was_trimmed),
  .cfg_ready   (cfg_ready)
);

// File: verif/sliding_quality_window_trimmer_tb.sv
// Self-checking testbench for the sliding quality window trimmer: predicts each read's result and checks it.
`timescale 1ns / 1ps

module sliding_quality_window_trimmer_tb;
  import sqwt_pkg::*;

  localparam int MAX_WINDOW    = 64;
  localparam int MAX_READ_LEN  = 65536;
  localparam int STALL_LIMIT   = 4000;
  localparam int RANDOM_SCORES = 550;
  localparam int RANDOM_READS  = 60;

  typedef struct {
    logic [SCORE_W-1:0] score;
    logic               last;
  } score_item_t;

  typedef struct {
    logic [KEPT_W-1:0] kept;
    logic              trimmed;
  } trim_result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   push = 1'b0;
  logic                   full;
  logic [SCORE_W-1:0]     quality_score = '0;
  logic                   end_of_read = 1'b0;
  logic                   empty;
  logic                   pop = 1'b0;
  logic [KEPT_W-1:0]      kept_length;
  logic                   was_trimmed;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  score_item_t  score_queue[$];
  trim_result_t expected_results[$];

  // Register copies and per-read state of the predictor.
  logic [WSIZE_W-1:0]  win_size_reg = WSIZE_RESET;
  logic [STEP_W-1:0]   win_step_reg = STEP_RESET;
  logic [THR_W-1:0]    thresh_reg = THR_RESET;
  logic [STREAK_W-1:0] streak_reg = STREAK_RESET;
  logic [SCORE_W-1:0]  score_ring[MAX_WINDOW];
  int unsigned         read_pos, phase_pos, low_run, cut_at;
  bit                  cut_hit;

  int          mismatches = 0;
  int          scores_sent = 0;
  int          reads_sent = 0;
  int          trims_predicted = 0;
  int          results_checked = 0;
  int          reg_writes = 0;
  bit          sender_gappy = 1'b0;
  int          rx_mode = 0;
  int          rx_hold_request = 0;
  int          rx_hold_left, burst_left, gap_left, idle_cycles;
  logic [15:0] rx_pattern;
  logic [3:0]  rx_tick;
  bit          offer_now;

  sliding_quality_window_trimmer dut (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .quality_score (quality_score),
    .end_of_read   (end_of_read),
    .empty         (empty),
    .pop           (pop),
    .kept_length   (kept_length),
    .was_trimmed   (was_trimmed),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int unsigned clamp_len(logic [6:0] v);
    if (v == 0) return 1;
    if (v > MAX_WINDOW) return MAX_WINDOW;
    return v;
  endfunction

  function automatic void clear_read();
    for (int i = 0; i < MAX_WINDOW; i++) score_ring[i] = '0;
    read_pos = 0;
    phase_pos = 0;
    low_run = 0;
    cut_hit = 1'b0;
    cut_at = 0;
  endfunction

  function automatic void predict_score(logic [SCORE_W-1:0] q, logic last);
    int unsigned w, st, s, total;
    trim_result_t res;
    w = clamp_len(win_size_reg);
    st = clamp_len(win_step_reg);
    if (read_pos < MAX_READ_LEN) begin
      score_ring[read_pos % MAX_WINDOW] = q;
      if (!cut_hit && read_pos + 1 >= w) begin
        s = read_pos + 1 - w;
        total = 0;
        for (int i = 0; i < w; i++) total += score_ring[(s + i) % MAX_WINDOW];
        if (phase_pos == 0) begin
          if (total <= thresh_reg * w) begin
            if (low_run < STREAK_MAX) low_run++;
          end else begin
            low_run = 0;
          end
          if (low_run == streak_reg) begin
            cut_hit = 1'b1;
            cut_at = s;
          end
        end
        phase_pos = (phase_pos + 1 >= st) ? 0 : phase_pos + 1;
      end
      read_pos++;
    end
    if (last) begin
      res.kept = cut_hit ? cut_at : read_pos;
      res.trimmed = cut_hit;
      if (cut_hit) trims_predicted++;
      expected_results.push_back(res);
      clear_read();
    end
  endfunction

  // Sender: bursts of random length, with random gaps between them when sender_gappy is set.
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
      burst_left = 0;
      gap_left = 0;
      clear_read();
    end else begin
      offer_now = push && full;
      if (push && !full) begin
        predict_score(score_queue[0].score, score_queue[0].last);
        score_queue.pop_front();
        if (burst_left > 0) burst_left--;
      end
      if (!offer_now) begin
        if (burst_left == 0) begin
          if (gap_left > 0) begin
            gap_left--;
          end else if (score_queue.size() != 0) begin
            burst_left = $urandom_range(1, 48);
            gap_left = sender_gappy ? $urandom_range(0, 12) : 0;
          end
        end
        offer_now = burst_left != 0 && score_queue.size() != 0;
      end
      push <= offer_now;
      if (offer_now) begin
        quality_score <= score_queue[0].score;
        end_of_read <= score_queue[0].last;
      end
    end
  end

  // Receiver: checks each popped result and stalls on a rotating pattern and during a requested hold.
  always @(posedge clk) begin
    trim_result_t want;
    if (rst) begin
      pop <= 1'b0;
      rx_hold_left = 0;
      rx_tick = '0;
      rx_pattern = '1;
    end else begin
      if (pop && !empty) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: kept_length %0d was_trimmed %0b", kept_length, was_trimmed);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          results_checked++;
          if (kept_length !== want.kept) begin
            $error("kept_length expected %0d actual %0d", want.kept, kept_length);
            mismatches++;
          end
          if (was_trimmed !== want.trimmed) begin
            $error("was_trimmed expected %0b actual %0b", want.trimmed, was_trimmed);
            mismatches++;
          end
        end
      end
      if (rx_hold_request != 0) begin
        rx_hold_left = rx_hold_request;
        rx_hold_request = 0;
      end
      if (rx_tick == 0) begin
        case (rx_mode)
          0: rx_pattern = '1;
          1: rx_pattern = $urandom;
          default: rx_pattern = $urandom & $urandom & $urandom;
        endcase
      end
      if (rx_hold_left != 0) begin
        rx_hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= rx_pattern[rx_tick];
      end
      rx_tick = rx_tick + 1;
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Timed out after %0d cycles with no handshake.", idle_cycles);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  task automatic write_reg(reg_index_t idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_WINDOW_SIZE:       win_size_reg = val[WSIZE_W-1:0];
      REG_WINDOW_STEP:       win_step_reg = val[STEP_W-1:0];
      REG_QUALITY_THRESHOLD: thresh_reg = val;
      REG_STREAK_NEEDED:     streak_reg = val;
    endcase
    reg_writes++;
    @(negedge clk);
  endtask

  task automatic set_all(logic [7:0] ws, logic [7:0] st, logic [7:0] thr, logic [7:0] strk);
    write_reg(REG_WINDOW_SIZE, ws);
    write_reg(REG_WINDOW_STEP, st);
    write_reg(REG_QUALITY_THRESHOLD, thr);
    write_reg(REG_STREAK_NEEDED, strk);
  endtask

  task automatic add_score(logic [SCORE_W-1:0] q, logic last);
    score_item_t it;
    it.score = q;
    it.last = last;
    score_queue.push_back(it);
    scores_sent++;
    if (last) reads_sent++;
  endtask

  task automatic wait_idle(int tail);
    do @(negedge clk); while (score_queue.size() != 0 || push || expected_results.size() != 0);
    repeat (tail) @(negedge clk);
  endtask

  function automatic logic [SCORE_W-1:0] pick_score(bit low);
    if (low) return $urandom_range(0, thresh_reg);
    if (thresh_reg == 8'hFF) return 8'hFF;
    return $urandom_range(thresh_reg + 1, 255);
  endfunction

  // Mostly a good stretch followed by a poor tail, sometimes pure noise.
  task automatic make_read();
    int unsigned len, good_len, i;
    bit noisy;
    len = $urandom_range(1, clamp_len(win_size_reg) + 4 * clamp_len(win_step_reg) + 12);
    good_len = $urandom_range(0, len);
    noisy = $urandom_range(0, 4) == 0;
    for (i = 0; i < len; i++) begin
      if (noisy) add_score($urandom_range(0, 255), i == len - 1);
      else if (i < good_len) add_score(pick_score(1'b0), i == len - 1);
      else add_score(pick_score($urandom_range(0, 9) != 0), i == len - 1);
    end
  endtask

  task automatic pick_settings();
    logic [7:0] ws, st, thr, strk;
    case ($urandom_range(0, 5))
      0: ws = 8'd0;
      1: ws = 8'd64;
      2: ws = 8'hFF;
      default: ws = $urandom_range(1, 12);
    endcase
    case ($urandom_range(0, 5))
      0: st = 8'd0;
      1: st = 8'd64;
      2: st = $urandom_range(65, 255);
      default: st = $urandom_range(1, 4);
    endcase
    case ($urandom_range(0, 4))
      0: thr = 8'd0;
      1: thr = 8'hFF;
      default: thr = $urandom_range(0, 255);
    endcase
    case ($urandom_range(0, 5))
      0: strk = 8'd0;
      1: strk = 8'hFF;
      default: strk = $urandom_range(1, 4);
    endcase
    set_all(ws, st, thr, strk);
  endtask

  initial begin
    int scores_base, reads_base;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings: a one-score read and a read that is cut after three low windows.
    add_score(8'hFF, 1'b1);
    for (int i = 0; i < 12; i++) add_score(8'h00, i == 11);
    wait_idle(8);

    set_all(8'd1, 8'd1, 8'hFF, 8'd1);
    add_score(8'hFF, 1'b0);
    add_score(8'h00, 1'b1);
    wait_idle(8);

    // Zero streak needed: the first good window cuts.
    set_all(8'd1, 8'd1, 8'd0, 8'd0);
    add_score(8'h00, 1'b0);
    add_score(8'h05, 1'b0);
    add_score(8'h00, 1'b1);
    wait_idle(8);

    // Out of range size and step values, then the largest window at its exact threshold sum.
    set_all(8'd0, 8'd0, 8'd10, 8'd2);
    add_score(8'd50, 1'b0);
    add_score(8'd3, 1'b0);
    add_score(8'd4, 1'b0);
    add_score(8'd90, 1'b1);
    wait_idle(8);
    set_all(8'hFF, 8'hFF, 8'hFF, 8'd1);
    for (int i = 0; i < 64; i++) add_score(8'hFF, i == 63);
    wait_idle(8);

    scores_base = scores_sent;
    reads_base = reads_sent;
    while (scores_sent < scores_base + RANDOM_SCORES || reads_sent < reads_base + RANDOM_READS)
    begin
      pick_settings();
      sender_gappy = $urandom_range(0, 2) != 0;
      rx_mode = $urandom_range(0, 2);
      repeat ($urandom_range(4, 10)) make_read();
      wait_idle(8);
    end

    // The receiver holds off while short reads keep arriving, so the block fills up.
    set_all(8'd2, 8'd1, 8'd30, 8'd1);
    sender_gappy = 1'b0;
    rx_mode = 0;
    rx_hold_request = 400;
    repeat (40) make_read();
    wait_idle(8);

    // Streak saturation with zero needed, then the largest streak count.
    set_all(8'd1, 8'd1, 8'd100, 8'd0);
    for (int i = 0; i < 300; i++) add_score($urandom_range(0, 100), 1'b0);
    add_score(8'd200, 1'b0);
    add_score(8'd7, 1'b1);
    wait_idle(8);
    write_reg(REG_STREAK_NEEDED, 8'hFF);
    for (int i = 0; i < 260; i++) add_score($urandom_range(0, 100), i == 259);
    wait_idle(8);

    // A read longer than the block counts.
    set_all(8'd10, 8'd1, 8'd0, 8'd1);
    for (int i = 0; i < MAX_READ_LEN + 4; i++)
      add_score($urandom_range(1, 255), i == MAX_READ_LEN + 3);
    wait_idle(24);

    if (expected_results.size() != 0) begin
      $error("%0d results never arrived", expected_results.size());
      mismatches++;
    end
    $display("Checked %0d results from %0d reads (%0d cut) and %0d scores, %0d register writes.",
             results_checked, reads_sent, trims_predicted, scores_sent, reg_writes);
    $display("Runs took in short reads, range limits, long streaks, a full stall, an overlong read.");
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
